>>> rtl/shs_pkg.sv
// ----------------------------------------------------------------------------
// shs_pkg
// Shared types, constants and round functions of the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
package shs_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned LenW   = 61;
  localparam logic [7:0]  PadByte = 8'h80;
  localparam logic [5:0]  LenPos  = 6'd56;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD80,
    ST_PADZ,
    ST_PADLEN,
    ST_ROUND,
    ST_FINAL,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    SEL_INPUT,
    SEL_PAD,
    SEL_ZERO,
    SEL_LEN
  } byte_sel_t;

  typedef struct packed {
    logic      push;
    byte_sel_t byte_sel;
    logic      len_inc;
    logic      round_en;
    logic      final_add;
    logic      out_adv;
    logic      restart;
  } cmd_t;

  typedef struct packed {
    logic fill_last;
    logic fill_at_len;
    logic round_last;
    logic out_last;
  } stat_t;

  function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
    return (v >> n) | (v << (32 - n));
  endfunction

  function automatic logic [31:0] big_sig0(input logic [31:0] v);
    return rotr(v, 2) ^ rotr(v, 13) ^ rotr(v, 22);
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] v);
    return rotr(v, 6) ^ rotr(v, 11) ^ rotr(v, 25);
  endfunction

  function automatic logic [31:0] small_sig0(input logic [31:0] v);
    return rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
  endfunction

  function automatic logic [31:0] small_sig1(input logic [31:0] v);
    return rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
  endfunction

endpackage

>>> rtl/shs_ctrl.sv
// ----------------------------------------------------------------------------
// shs_ctrl
// Sequencer: byte intake, padding, compression rounds and digest output.
// ----------------------------------------------------------------------------
module shs_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            has_byte,
  input  logic            end_of_message,
  output logic            out_valid,
  input  logic            out_ready,
  input  shs_pkg::stat_t  stat,
  output shs_pkg::cmd_t   cmd
);

  shs_pkg::state_t state, state_next;
  shs_pkg::state_t resume, resume_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= shs_pkg::ST_IDLE;
      resume <= shs_pkg::ST_IDLE;
    end else begin
      state  <= state_next;
      resume <= resume_next;
    end
  end

  always_comb begin
    state_next  = state;
    resume_next = resume;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    cmd         = '0;
    cmd.byte_sel = shs_pkg::SEL_INPUT;
    case (state)
      shs_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (has_byte) begin
            cmd.push    = 1'b1;
            cmd.len_inc = 1'b1;
          end
          if (has_byte && stat.fill_last) begin
            state_next  = shs_pkg::ST_ROUND;
            resume_next = end_of_message ? shs_pkg::ST_PAD80 : shs_pkg::ST_IDLE;
          end else if (end_of_message) begin
            state_next = shs_pkg::ST_PAD80;
          end
        end
      end
      shs_pkg::ST_PAD80: begin
        cmd.push     = 1'b1;
        cmd.byte_sel = shs_pkg::SEL_PAD;
        state_next   = stat.fill_last ? shs_pkg::ST_ROUND : shs_pkg::ST_PADZ;
        resume_next  = shs_pkg::ST_PADZ;
      end
      shs_pkg::ST_PADZ: begin
        if (stat.fill_at_len) begin
          state_next = shs_pkg::ST_PADLEN;
        end else begin
          cmd.push     = 1'b1;
          cmd.byte_sel = shs_pkg::SEL_ZERO;
          if (stat.fill_last) begin
            state_next  = shs_pkg::ST_ROUND;
            resume_next = shs_pkg::ST_PADZ;
          end
        end
      end
      shs_pkg::ST_PADLEN: begin
        cmd.push     = 1'b1;
        cmd.byte_sel = shs_pkg::SEL_LEN;
        if (stat.fill_last) begin
          state_next  = shs_pkg::ST_ROUND;
          resume_next = shs_pkg::ST_OUT;
        end
      end
      shs_pkg::ST_ROUND: begin
        cmd.round_en = 1'b1;
        if (stat.round_last) begin
          state_next = shs_pkg::ST_FINAL;
        end
      end
      shs_pkg::ST_FINAL: begin
        cmd.final_add = 1'b1;
        state_next    = resume;
      end
      shs_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.out_adv = 1'b1;
          if (stat.out_last) begin
            // digest delivered, start a fresh message
            cmd.restart = 1'b1;
            state_next  = shs_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = shs_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/shs_datapath.sv
// ----------------------------------------------------------------------------
// shs_datapath
// Block shift register (doubles as the rolling schedule), round variables,
// chaining words, fill and length counters and the digest word select.
// ----------------------------------------------------------------------------
module shs_datapath (
  input  logic           clk,
  input  logic           rst,
  input  logic [7:0]     data_byte,
  input  shs_pkg::cmd_t  cmd,
  output shs_pkg::stat_t stat,
  output logic [31:0]    digest_word,
  output logic [2:0]     word_index,
  output logic           last_word
);

  logic [511:0]                    msg;
  logic [7:0][31:0]                vars;
  logic [7:0][31:0]                chain;
  logic [5:0]                      fill;
  logic [shs_pkg::LenW-1:0]        len;
  logic [5:0]                      round_idx;
  logic [2:0]                      out_idx;

  logic [7:0]  push_byte;
  logic [63:0] len_bits;
  logic [5:0]  len_shift;
  logic [31:0] w_cur;
  logic [31:0] w_new;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] ch;
  logic [31:0] mj;
  logic        block_done;

  assign len_bits  = {len, 3'b000};
  // length goes out most significant byte first at block offsets 56..63
  assign len_shift = {~fill[2:0], 3'b000};

  always_comb begin
    case (cmd.byte_sel)
      shs_pkg::SEL_INPUT: push_byte = data_byte;
      shs_pkg::SEL_PAD:   push_byte = shs_pkg::PadByte;
      shs_pkg::SEL_ZERO:  push_byte = 8'h00;
      shs_pkg::SEL_LEN:   push_byte = 8'(len_bits >> len_shift);
      default:            push_byte = 8'h00;
    endcase
  end

  // window holds W[t] .. W[t+15], W[t] in the top word
  assign w_cur = msg[511:480];
  assign w_new = shs_pkg::small_sig1(msg[63:32]) + msg[223:192]
               + shs_pkg::small_sig0(msg[479:448]) + w_cur;

  assign ch = (vars[4] & vars[5]) ^ (~vars[4] & vars[6]);
  assign mj = (vars[0] & vars[1]) ^ (vars[0] & vars[2]) ^ (vars[1] & vars[2]);
  assign t1 = vars[7] + shs_pkg::big_sig1(vars[4]) + ch
            + shs_pkg::ROUND_K[round_idx] + w_cur;
  assign t2 = shs_pkg::big_sig0(vars[0]) + mj;

  assign block_done = cmd.push && (fill == 6'd63);

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      msg <= {msg[503:0], push_byte};
    end else if (cmd.round_en) begin
      msg <= {msg[479:0], w_new};
    end
  end

  always_ff @(posedge clk) begin
    if (block_done) begin
      vars <= chain;
    end else if (cmd.round_en) begin
      vars[7] <= vars[6];
      vars[6] <= vars[5];
      vars[5] <= vars[4];
      vars[4] <= vars[3] + t1;
      vars[3] <= vars[2];
      vars[2] <= vars[1];
      vars[1] <= vars[0];
      vars[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.restart) begin
      for (int i = 0; i < 8; i++) begin
        chain[i] <= shs_pkg::INIT_H[i];
      end
      fill    <= '0;
      len     <= '0;
      out_idx <= '0;
    end else begin
      if (cmd.final_add) begin
        for (int i = 0; i < 8; i++) begin
          chain[i] <= chain[i] + vars[i];
        end
      end
      if (cmd.push) begin
        fill <= fill + 6'd1;
      end
      if (cmd.len_inc) begin
        len <= len + 61'd1;
      end
      if (cmd.out_adv) begin
        out_idx <= out_idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      round_idx <= '0;
    end else if (block_done) begin
      round_idx <= '0;
    end else if (cmd.round_en) begin
      round_idx <= round_idx + 6'd1;
    end
  end

  assign stat.fill_last   = (fill == 6'd63);
  assign stat.fill_at_len = (fill == shs_pkg::LenPos);
  assign stat.round_last  = (round_idx == 6'd63);
  assign stat.out_last    = (out_idx == 3'd7);

  assign digest_word = chain[out_idx];
  assign word_index  = out_idx;
  assign last_word   = (out_idx == 3'd7);

endmodule

>>> rtl/sha256_stream_hasher.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// SHA-256 over a byte stream, eight digest words out per message.
// ----------------------------------------------------------------------------
// Each accepted item may add one byte to the current 64-byte block. The
// byte that completes a block starts a compression (64 rounds through a
// single round unit, then the chaining add), during which in_ready stays
// low. On end_of_message the block is padded one byte at a time (0x80,
// zeros up to offset 56, then the 8-byte bit length), so the tail costs
// one or two compressions, after which the eight digest words go out one
// per accepted result, word 0 first. The hasher then restarts for the next
// message; no item is taken from the end marker until the last digest word
// is accepted.
module sha256_stream_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        has_byte,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  shs_pkg::cmd_t  cmd;
  shs_pkg::stat_t stat;

  shs_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .has_byte       (has_byte),
    .end_of_message (end_of_message),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .stat           (stat),
    .cmd            (cmd)
  );

  shs_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .data_byte   (data_byte),
    .cmd         (cmd),
    .stat        (stat),
    .digest_word (digest_word),
    .word_index  (word_index),
    .last_word   (last_word)
  );

endmodule
